@@ sv/rgbct_pkg.sv @@
`default_nettype none
package rgbct_pkg;

    localparam int COORD_FRAC_BITS = 14;

    localparam int PROD_W = 34;
    localparam int XYZ_W  = 36;
    localparam int SUM_W  = 37;
    localparam int CO_W   = 22;

    localparam int DIV_QB  = 25;
    localparam int DIV_DW  = 37;
    localparam int DIV_NW  = DIV_DW + DIV_QB + 1;
    localparam int DIV_LAT = DIV_QB + 1;

    localparam int N_W  = 24;
    localparam int T1_W = 35;
    localparam int T2_W = 44;
    localparam int T3_W = 54;

    localparam logic signed [16:0] CF [9] = '{
        -17'sd4680,  17'sd50765, -17'sd31340,
        -17'sd10638, 17'sd51720, -17'sd23983,
        -17'sd22348, 17'sd25255,  17'sd18459
    };

    localparam longint C3320_L   = ((longint'(3320) << COORD_FRAC_BITS) + 5000) / 10000;
    localparam longint C1858_L   = ((longint'(1858) << COORD_FRAC_BITS) + 5000) / 10000;
    localparam longint QUARTER_L = (longint'(1) << COORD_FRAC_BITS) / 4;

    localparam logic signed [CO_W-1:0] C3320   = CO_W'(C3320_L);
    localparam logic signed [CO_W-1:0] C1858   = CO_W'(C1858_L);
    localparam logic signed [CO_W-1:0] QUARTER = CO_W'(QUARTER_L);

    localparam logic signed [T1_W-1:0] K449   = T1_W'(449);
    localparam logic signed [T1_W-1:0] K3525S = T1_W'(longint'(3525) << 16);
    localparam logic signed [T2_W-1:0] K6823  = T2_W'(447172198);
    localparam logic signed [T3_W-1:0] K5520  = T3_W'(361780347);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_REGION   = 2'd1,
        ST_SUM_ZERO = 2'd2,
        ST_DEN_ZERO = 2'd3
    } status_t;

    typedef struct packed {
        logic [15:0] lux;
        logic        sum_zero;
        logic        neg_x;
        logic        neg_y;
    } xy_side_t;

    typedef struct packed {
        logic [15:0]        lux;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        status_t            status;
    } res_side_t;

endpackage
`default_nettype wire

@@ sv/rgbct_pix_if.sv @@
`default_nettype none
interface rgbct_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] red_count;
    logic [15:0] green_count;
    logic [15:0] blue_count;

    modport source (output valid, output red_count, output green_count, output blue_count,
                    input ready);
    modport sink (input valid, input red_count, input green_count, input blue_count,
                  output ready);
endinterface
`default_nettype wire

@@ sv/rgbct_res_if.sv @@
`default_nettype none
interface rgbct_res_if;
    logic               valid;
    logic               ready;
    logic [15:0]        illuminance;
    logic signed [15:0] chroma_x;
    logic signed [15:0] chroma_y;
    logic [15:0]        color_temp;
    logic [1:0]         status;

    modport source (output valid, output illuminance, output chroma_x, output chroma_y,
                    output color_temp, output status, input ready);
    modport sink (input valid, input illuminance, input chroma_x, input chroma_y,
                  input color_temp, input status, output ready);
endinterface
`default_nettype wire

@@ sv/rgb_to_color_temperature_unit.sv @@
`default_nettype none
// Converts one RGB sensor triple per cycle into illuminance, chromaticity x/y
// (signed, COORD_FRAC_BITS fraction bits) and McCamy correlated color temperature.
// Fully pipelined: a new transfer is taken every cycle while the output side
// accepts. The x and y dividers run side by side, then the n divider; each is a
// bit-serial pipelined divider of 26 stages. A stall on the output holds the
// whole pipeline.
module rgb_to_color_temperature_unit
    import rgbct_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rgbct_pix_if.sink   pix,
    rgbct_res_if.source res
);

    localparam int TOT = 9 + 2 * DIV_LAT;
    localparam int I_S4 = 2 + DIV_LAT;
    localparam int I_S5 = 3 + 2 * DIV_LAT;

    function automatic logic signed [15:0] sat_coord(input logic neg,
                                                     input logic [DIV_QB-1:0] mag,
                                                     input logic of);
        logic signed [DIV_QB:0] sv;
        sv = $signed({1'b0, mag});
        if (neg)
            sv = -sv;
        if (of)
            return neg ? -16'sd32768 : 16'sd32767;
        else if (sv > 26'sd32767)
            return 16'sd32767;
        else if (sv < -26'sd32768)
            return -16'sd32768;
        else
            return sv[15:0];
    endfunction

    function automatic logic signed [N_W-1:0] sat_n(input logic neg,
                                                    input logic [DIV_QB-1:0] mag,
                                                    input logic of);
        logic signed [DIV_QB:0] sv;
        sv = $signed({1'b0, mag});
        if (neg)
            sv = -sv;
        if (of || sv > $signed((DIV_QB+1)'((1 << (N_W-1)) - 1)))
            return neg ? {1'b1, {(N_W-1){1'b0}}} : {1'b0, {(N_W-1){1'b1}}};
        else if (sv < -$signed((DIV_QB+1)'(1 << (N_W-1))))
            return {1'b1, {(N_W-1){1'b0}}};
        else
            return sv[N_W-1:0];
    endfunction

    logic           en;
    logic [TOT-1:0] vld_reg;

    assign en        = ~vld_reg[TOT-1] | res.ready;
    assign pix.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[TOT-2:0], pix.valid};
    end

    // stage 1: matrix products
    logic [15:0]              rgb [3];
    logic signed [PROD_W-1:0] prd_reg [9];

    assign rgb[0] = pix.red_count;
    assign rgb[1] = pix.green_count;
    assign rgb[2] = pix.blue_count;

    for (genvar k = 0; k < 9; k++)
    begin : g_mul
        logic signed [PROD_W-1:0] prd_next;
        assign prd_next = CF[k] * $signed({1'b0, rgb[k % 3]});
        always_ff @(posedge clk)
        begin
            if (en)
                prd_reg[k] <= prd_next;
        end
    end

    // stage 2: tristimulus
    logic signed [XYZ_W-1:0] tx_reg, ty_reg, tz_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tx_reg <= XYZ_W'(prd_reg[0]) + XYZ_W'(prd_reg[1]) + XYZ_W'(prd_reg[2]);
            ty_reg <= XYZ_W'(prd_reg[3]) + XYZ_W'(prd_reg[4]) + XYZ_W'(prd_reg[5]);
            tz_reg <= XYZ_W'(prd_reg[6]) + XYZ_W'(prd_reg[7]) + XYZ_W'(prd_reg[8]);
        end
    end

    // x, y division
    logic signed [SUM_W-1:0] sum_c;
    logic [XYZ_W-1:0]        ax_c, ay_c;
    logic [SUM_W-1:0]        as_c;
    logic [15:0]             lux_c;
    xy_side_t                sb1_reg [DIV_LAT];
    logic [DIV_QB-1:0]       qx, qy;
    logic                    ovx, ovy;

    always_comb
    begin
        sum_c = SUM_W'(tx_reg) + SUM_W'(ty_reg) + SUM_W'(tz_reg);
        ax_c  = tx_reg[XYZ_W-1] ? XYZ_W'(-tx_reg) : XYZ_W'(tx_reg);
        ay_c  = ty_reg[XYZ_W-1] ? XYZ_W'(-ty_reg) : XYZ_W'(ty_reg);
        as_c  = sum_c[SUM_W-1] ? SUM_W'(-sum_c) : SUM_W'(sum_c);
        if (ty_reg <= 0)
            lux_c = '0;
        else if (ty_reg[XYZ_W-1:31] != '0)
            lux_c = 16'hFFFF;
        else
            lux_c = ty_reg[30:15];
    end

    rgbct_div u_div_x (
        .clk (clk),
        .en  (en),
        .num (DIV_NW'(ax_c) << COORD_FRAC_BITS),
        .den (DIV_DW'(as_c)),
        .quo (qx),
        .ovf (ovx)
    );

    rgbct_div u_div_y (
        .clk (clk),
        .en  (en),
        .num (DIV_NW'(ay_c) << COORD_FRAC_BITS),
        .den (DIV_DW'(as_c)),
        .quo (qy),
        .ovf (ovy)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb1_reg[0] <= '{lux: lux_c, sum_zero: (sum_c == '0),
                            neg_x: tx_reg[XYZ_W-1] ^ sum_c[SUM_W-1],
                            neg_y: ty_reg[XYZ_W-1] ^ sum_c[SUM_W-1]};
            for (int i = 1; i < DIV_LAT; i++)
                sb1_reg[i] <= sb1_reg[i-1];
        end
    end

    // stage 4: saturate x, y and classify
    logic signed [15:0] cx_c, cy_c;
    status_t            st_c;
    res_side_t          s4_reg;

    always_comb
    begin
        cx_c = sat_coord(sb1_reg[DIV_LAT-1].neg_x, qx, ovx);
        cy_c = sat_coord(sb1_reg[DIV_LAT-1].neg_y, qy, ovy);
        if (sb1_reg[DIV_LAT-1].sum_zero)
        begin
            cx_c = '0;
            cy_c = '0;
            st_c = ST_SUM_ZERO;
        end
        else if (!(CO_W'(cx_c) > QUARTER && CO_W'(cy_c) > QUARTER))
            st_c = ST_REGION;
        else if (C1858 == CO_W'(cy_c))
            st_c = ST_DEN_ZERO;
        else
            st_c = ST_OK;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s4_reg <= '{lux: sb1_reg[DIV_LAT-1].lux, cx: cx_c, cy: cy_c, status: st_c};
    end

    // n division
    logic signed [CO_W-1:0] dn_c, dd_c;
    logic [CO_W-1:0]        an_c, ad_c;
    res_side_t              sb2_reg [DIV_LAT];
    logic [DIV_LAT-1:0]     negn_reg;
    logic [DIV_QB-1:0]      qn;
    logic                   ovn;

    always_comb
    begin
        dn_c = CO_W'(s4_reg.cx) - C3320;
        dd_c = C1858 - CO_W'(s4_reg.cy);
        an_c = dn_c[CO_W-1] ? CO_W'(-dn_c) : CO_W'(dn_c);
        ad_c = dd_c[CO_W-1] ? CO_W'(-dd_c) : CO_W'(dd_c);
    end

    rgbct_div u_div_n (
        .clk (clk),
        .en  (en),
        .num (DIV_NW'(an_c) << 16),
        .den (DIV_DW'(ad_c)),
        .quo (qn),
        .ovf (ovn)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb2_reg[0]  <= s4_reg;
            negn_reg[0] <= dn_c[CO_W-1] ^ dd_c[CO_W-1];
            for (int i = 1; i < DIV_LAT; i++)
            begin
                sb2_reg[i]  <= sb2_reg[i-1];
                negn_reg[i] <= negn_reg[i-1];
            end
        end
    end

    // cubic, Horner form
    logic signed [N_W-1:0]  n5_c;
    logic signed [N_W-1:0]  n5_reg, n6_reg, n7_reg;
    logic signed [T1_W-1:0] t1_reg;
    logic signed [41:0]     pl6_reg, ph6_reg;
    logic signed [58:0]     pr7_c;
    logic signed [T2_W-1:0] t2_reg;
    logic signed [46:0]     pl8_reg;
    logic signed [45:0]     ph8_reg;
    logic signed [67:0]     pr9_c;
    logic signed [T3_W-1:0] t3_reg;
    logic signed [T3_W-17:0] cc_c;
    logic [15:0]            cct_c;
    res_side_t              s_reg [5];

    assign n5_c  = sat_n(negn_reg[DIV_LAT-1], qn, ovn);
    assign pr7_c = (59'(ph6_reg) <<< 17) + 59'(pl6_reg);
    assign pr9_c = (68'(ph8_reg) <<< 22) + 68'(pl8_reg);
    assign cc_c  = (T3_W-16)'(t3_reg >>> 16);

    always_comb
    begin
        if (s_reg[4].status != ST_OK || cc_c < 0)
            cct_c = '0;
        else if (cc_c > 65535)
            cct_c = 16'hFFFF;
        else
            cct_c = cc_c[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n5_reg   <= n5_c;
            t1_reg   <= K449 * T1_W'(n5_c) + K3525S;
            s_reg[0] <= sb2_reg[DIV_LAT-1];

            n6_reg   <= n5_reg;
            pl6_reg  <= $signed({1'b0, t1_reg[16:0]}) * n5_reg;
            ph6_reg  <= $signed(t1_reg[T1_W-1:17]) * n5_reg;
            s_reg[1] <= s_reg[0];

            n7_reg   <= n6_reg;
            t2_reg   <= T2_W'(pr7_c >>> 16) + K6823;
            s_reg[2] <= s_reg[1];

            pl8_reg  <= $signed({1'b0, t2_reg[21:0]}) * n7_reg;
            ph8_reg  <= $signed(t2_reg[T2_W-1:22]) * n7_reg;
            s_reg[3] <= s_reg[2];

            t3_reg   <= T3_W'(pr9_c >>> 16) + K5520;
            s_reg[4] <= s_reg[3];
        end
    end

    // output register
    res_side_t   o_reg;
    logic [15:0] occt_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_reg    <= s_reg[4];
            occt_reg <= cct_c;
        end
    end

    assign res.valid       = vld_reg[TOT-1];
    assign res.illuminance = o_reg.lux;
    assign res.chroma_x    = o_reg.cx;
    assign res.chroma_y    = o_reg.cy;
    assign res.color_temp  = occt_reg;
    assign res.status      = o_reg.status;

`ifndef SYNTHESIS
    a_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.status == ST_SUM_ZERO |->
            res.chroma_x == '0 && res.chroma_y == '0 && res.color_temp == '0)
        else $error("sum zero result carries nonzero fields");

    a_no_cct: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.status != ST_OK |-> res.color_temp == '0)
        else $error("temperature given without a valid fit");

    a_region: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.status == ST_REGION |->
            !(CO_W'(res.chroma_x) > QUARTER && CO_W'(res.chroma_y) > QUARTER))
        else $error("region flag disagrees with chromaticity");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !pix.ready |-> res.valid && !res.ready)
        else $error("input stalled without an output stall");

    a_mid_valid: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[I_S4] && en |=> vld_reg[I_S4 + 1])
        else $error("valid lost entering n divider");

    a_s5_status: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[I_S5] && s_reg[0].status == ST_SUM_ZERO |-> s_reg[0].cx == '0)
        else $error("sum zero side data corrupted");
`endif

endmodule
`default_nettype wire

@@ sv/rgbct_div.sv @@
`default_nettype none
module rgbct_div
    import rgbct_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [DIV_NW-1:0] num,
    input  wire logic [DIV_DW-1:0] den,
    output logic      [DIV_QB-1:0] quo,
    output logic                   ovf
);

    logic [DIV_NW-1:0] rem_reg [DIV_QB];
    logic [DIV_DW-1:0] d_reg   [DIV_QB];
    logic [DIV_QB-1:0] q_reg   [DIV_QB+1];
    logic              ovf_reg [DIV_QB+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            d_reg[0]   <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= num >= (DIV_NW'(den) << DIV_QB);
        end
    end

    for (genvar k = 0; k < DIV_QB; k++)
    begin : g_step
        localparam int SH = DIV_QB - 1 - k;
        logic [DIV_NW:0]   trial;
        logic [DIV_QB-1:0] q_next;

        assign trial = {1'b0, rem_reg[k]} - {1'b0, DIV_NW'(d_reg[k]) << SH};

        always_comb
        begin
            q_next     = q_reg[k];
            q_next[SH] = ~trial[DIV_NW];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k+1]   <= q_next;
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end

        if (k < DIV_QB - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= trial[DIV_NW] ? rem_reg[k] : trial[DIV_NW-1:0];
                    d_reg[k+1]   <= d_reg[k];
                end
            end
        end
    end

    assign quo = q_reg[DIV_QB];
    assign ovf = ovf_reg[DIV_QB];

endmodule
`default_nettype wire

@@ bench/rgb_to_color_temperature_unit_tb.sv @@
`default_nettype none
module rgb_to_color_temperature_unit_tb;
    import rgbct_pkg::*;

    typedef struct {
        logic [15:0] lux;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] cct;
        logic [1:0]  status;
    } cct_result_t;

    typedef struct {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        bit          known;
        cct_result_t res;
    } pix_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    rgbct_pix_if pix ();
    rgbct_res_if res ();

    rgb_to_color_temperature_unit dut (
        .clk  (clk),
        .rst_n(rst_n),
        .pix  (pix.sink),
        .res  (res.source)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    cct_result_t pending_q[$];
    int          errors = 0;
    longint      cycles = 0;
    bit          src_done = 1'b0;
    bit          hold_long = 1'b0;
    pix_row_t    rows[$];

    function automatic longint floor16(longint v);
        return v >>> 16;
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic cct_result_t mccamy(logic [15:0] r, logic [15:0] g, logic [15:0] b);
        cct_result_t o;
        longint ri, gi, bi, one, c33, c18, qtr, tx, ty, tz, s, lux, cx, cy, den, n, t;
        ri = r; gi = g; bi = b;
        one = longint'(1) << COORD_FRAC_BITS;
        c33 = ((longint'(3320) << COORD_FRAC_BITS) + 5000) / 10000;
        c18 = ((longint'(1858) << COORD_FRAC_BITS) + 5000) / 10000;
        qtr = one / 4;
        tx = -4680 * ri + 50765 * gi - 31340 * bi;
        ty = -10638 * ri + 51720 * gi - 23983 * bi;
        tz = -22348 * ri + 25255 * gi + 18459 * bi;
        s = tx + ty + tz;
        lux = ty > 0 ? ty >> 15 : 0;
        o.lux = 16'(clampl(lux, 0, 65535));
        o.cx = '0; o.cy = '0; o.cct = '0;
        if (s == 0)
            o.status = ST_SUM_ZERO;
        else
        begin
            cx = clampl((tx * one) / s, -32768, 32767);
            cy = clampl((ty * one) / s, -32768, 32767);
            o.cx = 16'(cx); o.cy = 16'(cy);
            if (!(cx > qtr && cy > qtr))
                o.status = ST_REGION;
            else
            begin
                den = c18 - cy;
                if (den == 0)
                    o.status = ST_DEN_ZERO;
                else
                begin
                    n = clampl(((cx - c33) * 65536) / den, -(longint'(1) << 23),
                               (longint'(1) << 23) - 1);
                    t = 449 * n + (longint'(3525) << 16);
                    t = floor16(t * n) + 447172198;
                    t = floor16(t * n) + 361780347;
                    o.cct = 16'(clampl(floor16(t), 0, 65535));
                    o.status = ST_OK;
                end
            end
        end
        return o;
    endfunction

    task automatic add_row(logic [15:0] r, logic [15:0] g, logic [15:0] b, bit known,
                           cct_result_t e);
        pix_row_t w;
        w.r = r; w.g = g; w.b = b; w.known = known; w.res = e;
        rows.push_back(w);
    endtask

    task automatic send(logic [15:0] r, logic [15:0] g, logic [15:0] b);
        int gap;
        gap = $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix.valid <= 1'b1;
        pix.red_count <= r;
        pix.green_count <= g;
        pix.blue_count <= b;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
    endtask

    initial
    begin
        cct_result_t z;
        cct_result_t e;
        logic [15:0] r, g, b;
        int k;
        pix.valid = 1'b0;
        pix.red_count = '0;
        pix.green_count = '0;
        pix.blue_count = '0;
        z.lux = '0; z.cx = '0; z.cy = '0; z.cct = '0; z.status = ST_SUM_ZERO;
        add_row(16'd0, 16'd0, 16'd0, 1'b1, z);
        add_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, z);
        add_row(16'hFFFF, 16'd0, 16'd0, 1'b0, z);
        add_row(16'd0, 16'hFFFF, 16'd0, 1'b0, z);
        add_row(16'd0, 16'd0, 16'hFFFF, 1'b0, z);
        add_row(16'd0, 16'hFFFF, 16'hFFFF, 1'b0, z);
        add_row(16'hFFFF, 16'hFFFF, 16'd0, 1'b0, z);
        add_row(16'hFFFF, 16'd0, 16'hFFFF, 1'b0, z);
        add_row(16'd1, 16'd1, 16'd1, 1'b0, z);
        add_row(16'd1000, 16'd1000, 16'd1000, 1'b0, z);
        add_row(16'd2000, 16'd1500, 16'd800, 1'b0, z);
        add_row(16'd800, 16'd1500, 16'd2000, 1'b0, z);
        add_row(16'd3000, 16'd1000, 16'd500, 1'b0, z);
        add_row(16'd500, 16'd3000, 16'd500, 1'b0, z);
        add_row(16'd1234, 16'd2345, 16'd1100, 1'b0, z);
        add_row(16'h5555, 16'hAAAA, 16'h5555, 1'b0, z);
        add_row(16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, z);
        add_row(16'd10, 16'd40, 16'd5, 1'b0, z);
        @(posedge clk);
        @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
        begin
            e = rows[i].known ? rows[i].res : mccamy(rows[i].r, rows[i].g, rows[i].b);
            pending_q.push_back(e);
            send(rows[i].r, rows[i].g, rows[i].b);
        end
        pix.valid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
        for (k = 0; k < 1050; k++)
        begin
            if (k == 300)
                hold_long <= 1'b1;
            if (k == 700)
            begin
                pix.valid <= 1'b0;
                @(posedge clk);
                while (pending_q.size() != 0)
                    @(posedge clk);
            end
            case ($urandom_range(0, 3))
                0:
                begin
                    r = 16'($urandom); g = 16'($urandom); b = 16'($urandom);
                end
                1:
                begin
                    g = 16'($urandom_range(100, 65535));
                    r = 16'(g * $urandom_range(40, 160) / 100);
                    b = 16'(g * $urandom_range(20, 120) / 100);
                end
                2:
                begin
                    g = 16'($urandom_range(0, 64));
                    r = 16'($urandom_range(0, 64));
                    b = 16'($urandom_range(0, 64));
                end
                default:
                begin
                    g = 16'($urandom_range(1, 8000));
                    r = 16'(g + $urandom_range(0, 800) - 400);
                    b = 16'(g / 2 + $urandom_range(0, 600));
                end
            endcase
            pending_q.push_back(mccamy(r, g, b));
            send(r, g, b);
        end
        pix.valid <= 1'b0;
        src_done <= 1'b1;
    end

    initial
    begin
        int gap;
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_long)
            begin
                res.ready <= 1'b0;
                repeat (200) @(posedge clk);
                hold_long = 1'b0;
            end
            gap = $urandom_range(0, 14);
            if ($urandom_range(0, 2) == 0)
                gap = 0;
            if (gap != 0)
            begin
                res.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res.ready <= 1'b1;
            @(posedge clk);
            while (!res.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        cct_result_t e;
        if (rst_n && res.valid && res.ready)
        begin
            if (pending_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transfer, got lux %h x %h y %h cct %h st %0d",
                         $time, res.illuminance, res.chroma_x, res.chroma_y,
                         res.color_temp, res.status);
            end
            else
            begin
                e = pending_q.pop_front();
                if (res.illuminance !== e.lux || res.chroma_x !== e.cx ||
                    res.chroma_y !== e.cy || res.color_temp !== e.cct ||
                    res.status !== e.status)
                begin
                    errors++;
                    $display("%0t: expected lux %h x %h y %h cct %h st %0d", $time,
                             e.lux, e.cx, e.cy, e.cct, e.status);
                    $display("%0t: actual   lux %h x %h y %h cct %h st %0d", $time,
                             res.illuminance, res.chroma_x, res.chroma_y,
                             res.color_temp, res.status);
                end
            end
        end
    end

    initial
    begin
        wait (src_done);
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0 && pending_q.size() == 0)
            $display("rgb_to_color_temperature_unit: match");
        else
            $display("rgb_to_color_temperature_unit: mismatch");
        $finish;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 200000)
        begin
            $display("rgb_to_color_temperature_unit: mismatch");
            $finish;
        end
    end
endmodule
`default_nettype wire
